### rtl/axis_argmax_argmin_defines.svh
// Assertion macros for the argmax/argmin block.
`ifndef AXIS_ARGMAX_ARGMIN_DEFINES_SVH
`define AXIS_ARGMAX_ARGMIN_DEFINES_SVH
`ifndef ASSERT_OFF
`define AA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AA_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define AA_ASSERT(label, clk, rst_n, prop, msg)
`define AA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### rtl/aam_pkg.sv
package aam_pkg;
    localparam int INNER_MAX_DEF = 1024;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 24;
    localparam int RUN_W = 25;
    localparam int CNT_W = 11;
    localparam logic [24:0] RUN_MAX = 25'h1000000;
    localparam logic [31:0] NEG_FLT_MAX = 32'hFF7FFFFF;
    localparam logic [31:0] POS_FLT_MAX = 32'h7F7FFFFF;
    localparam logic [1:0] REG_FIND_MIN = 2'd0;
    localparam logic [1:0] REG_RUN_LENGTH = 2'd1;
    localparam logic [1:0] REG_INNER_COUNT = 2'd2;

    // IEEE strict a < b; false on NaN, +0 == -0
    function automatic logic fp_less(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic r;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        if (a_nan || b_nan)
            r = 1'b0;
        else if ((a[30:0] == '0) && (b[30:0] == '0))
            r = 1'b0;
        else if (a[31] != b[31])
            r = a[31];
        else if (!a[31])
            r = a[30:0] < b[30:0];
        else
            r = a[30:0] > b[30:0];
        return r;
    endfunction
endpackage

### rtl/aam_stream_if.sv
interface aam_stream_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/aam_cfg_if.sv
interface aam_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

### rtl/aam_ram.sv
module aam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

### rtl/axis_argmax_argmin.sv
// Channel   Dir  Payload              Request accepted when
// in_ch     in   value [31:0]         valid && ready
// out_ch    out  best_index [23:0]    valid && ready
// cfg_ch    in   index[1:0], wdata    valid && ready
//
// One element per cycle while the output queue has room; two-stage pipe (RAM read, compare/write).
// A request is registered into stage 1; its result is then written to the output queue.
// Best value/index live in two 1-port-write RAMs; back-to-back hits on the
// same slot (inner_count 1) are forwarded from the write stage.
// rst_n is asynchronous; RAMs need no clearing since row 0 overwrites a slot.
// A stalled result holds a four-entry output queue; input stalls when the
// queue plus the request in stage 1 leave no room for one more.
`include "axis_argmax_argmin_defines.svh"
module axis_argmax_argmin
    import aam_pkg::*;
#(
    parameter int INNER_MAX = INNER_MAX_DEF
) (
    input logic       clk,
    input logic       rst_n,
    aam_stream_if.sink   in_ch,
    aam_stream_if.source out_ch,
    aam_cfg_if.sink      cfg_ch
);
    localparam int AW = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
    localparam int RD = (INNER_MAX > 1) ? INNER_MAX : 2;
    localparam logic [CNT_W+6:0] INNER_MAX_C = (CNT_W+7)'(INNER_MAX);

    // configuration registers
    logic              find_min_reg;
    logic [RUN_W-1:0]  run_length_reg;
    logic [CNT_W+6:0]  inner_count_reg;
    logic [RUN_W-1:0]  run_eff;
    logic [CNT_W+6:0]  inner_eff;

    always_comb
    begin
        run_eff = run_length_reg;
        if (run_length_reg == '0)
            run_eff = RUN_W'(1);
        else if (run_length_reg > RUN_MAX)
            run_eff = RUN_MAX;
        inner_eff = inner_count_reg;
        if (inner_count_reg == '0)
            inner_eff = (CNT_W+7)'(1);
        else if (inner_count_reg > INNER_MAX_C)
            inner_eff = INNER_MAX_C;
    end

    // position counters
    logic [INDEX_W-1:0] row_reg;
    logic [AW-1:0]      slot_reg;
    logic [CNT_W+6:0]   inner_pos_reg;

    logic in_fire;
    logic cfg_fire;
    logic cfg_hit;
    logic row_last;
    logic inner_last;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
    assign cfg_hit  = cfg_fire && (cfg_ch.index == REG_FIND_MIN ||
                      cfg_ch.index == REG_RUN_LENGTH || cfg_ch.index == REG_INNER_COUNT);
    assign row_last   = ({1'b0, row_reg} + (INDEX_W+1)'(1)) >= run_eff;
    assign inner_last = (inner_pos_reg + (CNT_W+7)'(1)) >= inner_eff;
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            find_min_reg    <= 1'b0;
            run_length_reg  <= RUN_W'(1);
            inner_count_reg <= (CNT_W+7)'(1);
            row_reg         <= '0;
            slot_reg        <= '0;
            inner_pos_reg   <= '0;
        end
        else if (cfg_hit)
        begin
            case (cfg_ch.index)
                REG_FIND_MIN:    find_min_reg <= cfg_ch.wdata[0];
                REG_RUN_LENGTH:  run_length_reg <= cfg_ch.wdata[RUN_W-1:0];
                REG_INNER_COUNT: inner_count_reg <= {7'd0, cfg_ch.wdata[CNT_W-1:0]};
                default:         find_min_reg <= find_min_reg;
            endcase
            row_reg       <= '0;
            slot_reg      <= '0;
            inner_pos_reg <= '0;
        end
        else if (in_fire)
        begin
            if (inner_last)
            begin
                inner_pos_reg <= '0;
                slot_reg      <= '0;
                row_reg       <= row_last ? '0 : row_reg + INDEX_W'(1);
            end
            else
            begin
                inner_pos_reg <= inner_pos_reg + (CNT_W+7)'(1);
                slot_reg      <= slot_reg + AW'(1);
            end
        end
    end

    // stage 1: RAM read in flight
    logic               s1_valid_reg;
    logic [AW-1:0]      s1_slot_reg;
    logic [INDEX_W-1:0] s1_row_reg;
    logic               s1_last_reg;
    logic [VALUE_W-1:0] s1_value_reg;

    logic [VALUE_W-1:0] ram_val_rd;
    logic [INDEX_W-1:0] ram_idx_rd;

    // stage 2 write-back (also forwarding source)
    logic               wb_valid_reg;
    logic [AW-1:0]      wb_slot_reg;
    logic [VALUE_W-1:0] wb_val_reg;
    logic [INDEX_W-1:0] wb_idx_reg;

    logic [VALUE_W-1:0] cur_val;
    logic [INDEX_W-1:0] cur_idx;
    logic [VALUE_W-1:0] new_val;
    logic [INDEX_W-1:0] new_idx;
    logic               better;

    always_comb
    begin
        cur_val = ram_val_rd;
        cur_idx = ram_idx_rd;
        if (wb_valid_reg && wb_slot_reg == s1_slot_reg)
        begin
            cur_val = wb_val_reg;
            cur_idx = wb_idx_reg;
        end
        if (s1_row_reg == '0)
        begin
            cur_val = find_min_reg ? POS_FLT_MAX : NEG_FLT_MAX;
            cur_idx = '0;
        end
        better = find_min_reg ? fp_less(s1_value_reg, cur_val)
                              : fp_less(cur_val, s1_value_reg);
        new_val = better ? s1_value_reg : cur_val;
        new_idx = better ? s1_row_reg : cur_idx;
    end

    aam_ram #(.WIDTH(VALUE_W), .DEPTH(RD)) u_val_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_slot_reg),
        .wdata (new_val),
        .raddr (slot_reg),
        .rdata (ram_val_rd)
    );

    aam_ram #(.WIDTH(INDEX_W), .DEPTH(RD)) u_idx_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_slot_reg),
        .wdata (new_idx),
        .raddr (slot_reg),
        .rdata (ram_idx_rd)
    );

    // output queue, four entries
    logic [INDEX_W-1:0] q_data_reg [4];
    logic [2:0]         q_cnt_reg;
    logic [1:0]         q_rd_reg;
    logic [1:0]         q_wr_reg;
    logic               push;
    logic               pop;

    assign push = s1_valid_reg && s1_last_reg;
    assign pop  = out_ch.valid && out_ch.ready;
    // room for what is in flight: stage 1 may push one more
    assign in_ch.ready = (q_cnt_reg + {2'b00, push}) <= 3'd3;
    assign out_ch.valid = q_cnt_reg != 3'd0;
    assign out_ch.data  = q_data_reg[q_rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_data_reg[q_wr_reg] <= new_idx;
        if (in_fire)
        begin
            s1_slot_reg  <= slot_reg;
            s1_row_reg   <= row_reg;
            s1_last_reg  <= row_last;
            s1_value_reg <= in_ch.data;
        end
        if (s1_valid_reg)
        begin
            wb_slot_reg <= s1_slot_reg;
            wb_val_reg  <= new_val;
            wb_idx_reg  <= new_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
            q_cnt_reg    <= '0;
            q_rd_reg     <= '0;
            q_wr_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
            wb_valid_reg <= s1_valid_reg;
            if (push)
                q_wr_reg <= q_wr_reg + 2'd1;
            if (pop)
                q_rd_reg <= q_rd_reg + 2'd1;
            q_cnt_reg <= q_cnt_reg + {2'b00, push} - {2'b00, pop};
        end
    end

    `AA_ASSERT(a_q_bound, clk, rst_n, q_cnt_reg <= 3'd4, "output queue overflow")
    `AA_ASSERT(a_no_push_full, clk, rst_n, !(push && !pop && q_cnt_reg == 3'd4),
               "push into full queue")
    `AA_ASSERT(a_s1_follows, clk, rst_n, in_fire |=> s1_valid_reg, "stage 1 lost request")
    `AA_ASSERT(a_ready_full, clk, rst_n, (q_cnt_reg == 3'd4) |-> !in_ch.ready,
               "ready while queue full")
endmodule
